/* hdl/lcdw_pkg.sv */
// Shared types, command codes and defaults for the LCD window pixel writer.
package lcdw_pkg;

  localparam int PANEL_WIDTH_DEF  = 320;
  localparam int PANEL_HEIGHT_DEF = 480;

  localparam logic [15:0] CMD_CASET  = 16'h002A;
  localparam logic [15:0] CMD_PASET  = 16'h002B;
  localparam logic [15:0] CMD_RAMWR  = 16'h002C;
  localparam logic [15:0] CMD_MADCTL = 16'h0036;

  // Last parameter index of each parameterised command (length minus one).
  localparam logic [2:0] WIN_LAST_IDX    = 3'd3;
  localparam logic [2:0] MADCTL_LAST_IDX = 3'd0;

  typedef enum logic {
    RES_PIXEL   = 1'b0,
    RES_LEN_ERR = 1'b1
  } res_kind_t;

  typedef struct packed {
    logic        reset_low;
    logic        is_command;
    logic [15:0] data_word;
    logic        last_in_transfer;
  } in_item_t;

  typedef struct packed {
    res_kind_t   result_kind;
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
    logic [23:0] pixel_rgb;
  } out_item_t;

  // A result from the core, qualified by whether the item produced one.
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } res_t;

  // Handshake state of the input register as seen by the rest of the block.
  typedef struct packed {
    logic     fire;
    in_item_t item;
  } stage_t;

endpackage

/* hdl/lcdw_in_reg.sv */
// Input register stage: holds one accepted item until the core can take it.
module lcdw_in_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lcdw_pkg::in_item_t in_item,
  input  logic               out_free,
  output lcdw_pkg::stage_t   stage
);

  logic               s_valid_r;
  logic               s_valid_nxt;
  lcdw_pkg::in_item_t s_item_r;
  logic               accept;
  logic               fire;

  assign fire     = s_valid_r && out_free;
  assign in_stall = s_valid_r && !out_free;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    s_valid_nxt = s_valid_r;
    if (accept) begin
      s_valid_nxt = 1'b1;
    end else if (fire) begin
      s_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else begin
      s_valid_r <= s_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_item_r <= in_item;
    end
  end

  assign stage.fire = fire;
  assign stage.item = s_item_r;

endmodule

/* hdl/lcdw_core.sv */
// Command decode, window and cursor state, and pixel mapping for one item.
module lcdw_core #(
  parameter int PANEL_WIDTH  = lcdw_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = lcdw_pkg::PANEL_HEIGHT_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  lcdw_pkg::stage_t stage,
  output lcdw_pkg::res_t   res
);

  localparam logic [15:0] W_M1 = 16'(PANEL_WIDTH - 1);
  localparam logic [15:0] H_M1 = 16'(PANEL_HEIGHT - 1);

  logic [15:0] cmd_r, cmd_nxt;
  logic [15:0] col_start_r, col_start_nxt;
  logic [15:0] col_end_r, col_end_nxt;
  logic [15:0] page_start_r, page_start_nxt;
  logic [15:0] page_end_r, page_end_nxt;
  logic [15:0] cur_col_r, cur_col_nxt;
  logic [15:0] cur_row_r, cur_row_nxt;
  logic [2:0]  orient_r, orient_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [15:0] pw_r [3];

  logic        pw_we;
  logic [1:0]  pw_idx;
  logic [2:0]  last_idx;
  logic [15:0] w;
  logic [15:0] win_s;
  logic [15:0] win_e;
  logic [15:0] px;
  logic [15:0] py;
  logic [15:0] swap_t;
  logic [23:0] rgb;

  assign w        = stage.item.data_word;
  assign last_idx = (cmd_r == lcdw_pkg::CMD_MADCTL) ? lcdw_pkg::MADCTL_LAST_IDX
                                                    : lcdw_pkg::WIN_LAST_IDX;
  assign win_s    = {pw_r[0][7:0], 8'h00} + pw_r[1];
  assign win_e    = {pw_r[2][7:0], 8'h00} + w;
  assign rgb      = {w[15:11], w[15:13], w[10:5], w[10:9], w[4:0], w[4:2]};

  // Orientation: bit 0 swaps rows and columns, bit 2 mirrors rows, and a
  // clear bit 1 mirrors columns.
  always_comb begin
    px     = cur_col_r;
    py     = cur_row_r;
    swap_t = px;
    if (orient_r[0]) begin
      px = py;
      py = swap_t;
    end
    if (orient_r[2]) begin
      py = H_M1 - py;
    end
    if (!orient_r[1]) begin
      px = W_M1 - px;
    end
  end

  always_comb begin
    cmd_nxt        = cmd_r;
    col_start_nxt  = col_start_r;
    col_end_nxt    = col_end_r;
    page_start_nxt = page_start_r;
    page_end_nxt   = page_end_r;
    cur_col_nxt    = cur_col_r;
    cur_row_nxt    = cur_row_r;
    orient_nxt     = orient_r;
    cnt_nxt        = cnt_r;
    pw_we          = 1'b0;
    pw_idx         = cnt_r[1:0];
    res            = '0;

    if (stage.fire && !stage.item.reset_low) begin
      if (stage.item.is_command) begin
        cmd_nxt = w;
        cnt_nxt = 3'd0;
        if (!stage.item.last_in_transfer) begin
          res.valid            = 1'b1;
          res.item.result_kind = lcdw_pkg::RES_LEN_ERR;
        end
      end else begin
        case (cmd_r)
          lcdw_pkg::CMD_RAMWR: begin
            res.valid            = 1'b1;
            res.item.result_kind = lcdw_pkg::RES_PIXEL;
            res.item.pixel_x     = px;
            res.item.pixel_y     = py;
            res.item.pixel_rgb   = rgb;
            if (cur_col_r < col_end_r) begin
              cur_col_nxt = cur_col_r + 16'd1;
            end else begin
              cur_col_nxt = col_start_r;
              cur_row_nxt = cur_row_r + 16'd1;
            end
          end
          lcdw_pkg::CMD_CASET, lcdw_pkg::CMD_PASET, lcdw_pkg::CMD_MADCTL: begin
            if (stage.item.last_in_transfer) begin
              cnt_nxt = 3'd0;
              if (cnt_r == last_idx) begin
                if (cmd_r == lcdw_pkg::CMD_MADCTL) begin
                  orient_nxt = w[7:5];
                end else if (cmd_r == lcdw_pkg::CMD_CASET) begin
                  col_start_nxt = win_s;
                  col_end_nxt   = win_e;
                  cur_col_nxt   = win_s;
                  cur_row_nxt   = page_start_r;
                end else begin
                  page_start_nxt = win_s;
                  page_end_nxt   = win_e;
                  cur_col_nxt    = col_start_r;
                  cur_row_nxt    = win_s;
                end
              end else begin
                res.valid            = 1'b1;
                res.item.result_kind = lcdw_pkg::RES_LEN_ERR;
              end
            end else begin
              // The count saturates one past the last index so that an
              // over-long transfer still reports a length error.
              pw_we   = (cnt_r < last_idx);
              cnt_nxt = (cnt_r <= last_idx) ? cnt_r + 3'd1 : cnt_r;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r        <= '0;
      col_start_r  <= '0;
      col_end_r    <= '0;
      page_start_r <= '0;
      page_end_r   <= '0;
      cur_col_r    <= '0;
      cur_row_r    <= '0;
      orient_r     <= '0;
      cnt_r        <= '0;
    end else begin
      cmd_r        <= cmd_nxt;
      col_start_r  <= col_start_nxt;
      col_end_r    <= col_end_nxt;
      page_start_r <= page_start_nxt;
      page_end_r   <= page_end_nxt;
      cur_col_r    <= cur_col_nxt;
      cur_row_r    <= cur_row_nxt;
      orient_r     <= orient_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pw_we) begin
      pw_r[pw_idx] <= w;
    end
  end

endmodule

/* hdl/lcdw_out_reg.sv */
// Result register: holds one result item until the receiver takes it.
module lcdw_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  lcdw_pkg::res_t      res,
  output logic                out_free,
  output logic                out_valid,
  input  logic                out_stall,
  output lcdw_pkg::out_item_t out_item
);

  logic                out_valid_r;
  logic                out_valid_nxt;
  lcdw_pkg::out_item_t out_item_r;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = res.valid;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res.valid) begin
      out_item_r <= res.item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

/* hdl/lcd_window_pixel_writer.sv */
// Top level of the LCD window pixel writer: input register, core and result register.
//
// This block takes one SPI word per item, together with the reset and
// data/command pin levels, and turns RAMWR data into pixel writes inside the
// column and page window set by CASET and PASET, mapped through the MADCTL
// swap and mirror bits. It sustains one item per clock cycle while the
// receiver does not stall the output: an accepted item sits in the input
// register until the result register is free, the core updates the command,
// window, cursor and orientation state and forms the result in the cycle the
// item leaves that register, and the result lands in the result register. A
// pixel or a length error item therefore passes the input register and then
// the result register before it shows on out_valid. Words that cause no
// result (commands ending a transfer, parameters, ignored words) simply pass
// through without occupying the result register. The output stall reaches
// in_stall combinationally, only when both registers are full, so the input
// keeps flowing while the receiver takes each result. PANEL_WIDTH and
// PANEL_HEIGHT set the mirror axes; all coordinates wrap at 16 bits.
module lcd_window_pixel_writer #(
  parameter int PANEL_WIDTH  = lcdw_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = lcdw_pkg::PANEL_HEIGHT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lcdw_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output lcdw_pkg::out_item_t out_item
);

  lcdw_pkg::stage_t stage;
  lcdw_pkg::res_t   res;
  logic             out_free;

  // The input register advances whenever the result register can take a
  // result this cycle.
  lcdw_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_free (out_free),
    .stage    (stage)
  );

  // All per-item state lives in the core; it only changes when an item fires.
  lcdw_core #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .stage (stage),
    .res   (res)
  );

  lcdw_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (stage.fire),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

/* hdl/lcdw_checker.sv */
// Port-level checks for the LCD window pixel writer, bound to the top level.
module lcdw_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input lcdw_pkg::in_item_t  in_item,
  input logic                out_valid,
  input logic                out_stall,
  input lcdw_pkg::out_item_t out_item
);

  // The input side only backs up when a result is held and stalled.
  a_stall_needs_full_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the result register could drain");

  // A length error item carries no coordinates and no color.
  a_error_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.result_kind == lcdw_pkg::RES_LEN_ERR) |->
      (out_item.pixel_x == 16'd0 && out_item.pixel_y == 16'd0 &&
       out_item.pixel_rgb == 24'd0))
    else $error("length error item with nonzero pixel fields");

  // Reset empties the result register.
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_item)))
    else $error("stalled result changed");

  // A stalled input item holds until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_stall) |=> (in_valid && $stable(in_item)))
    else $error("stalled input item changed");

endmodule

bind lcd_window_pixel_writer lcdw_checker u_lcdw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

/* bench/lcd_window_pixel_writer_tb.sv */
// Self-checking testbench for the LCD window pixel writer: directed rows, then random traffic.
module lcd_window_pixel_writer_tb;

  localparam int PANEL_W = lcdw_pkg::PANEL_WIDTH_DEF;
  localparam int PANEL_H = lcdw_pkg::PANEL_HEIGHT_DEF;

  // How a directed row is checked: by the predictor, as producing nothing,
  // or against the result typed into the row.
  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_SILENT,
    ROW_FIXED
  } row_check_t;

  typedef struct packed {
    row_check_t          check;
    lcdw_pkg::in_item_t  stim;
    lcdw_pkg::out_item_t want;
  } stim_row_t;

  localparam lcdw_pkg::out_item_t NO_OUT  = '0;
  localparam lcdw_pkg::out_item_t LEN_ERR =
    '{lcdw_pkg::RES_LEN_ERR, 16'h0000, 16'h0000, 24'h000000};

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  lcdw_pkg::in_item_t  in_item   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  lcdw_pkg::out_item_t out_item;

  int                  send_idle_pct  = 0;
  int                  recv_stall_pct = 0;
  int                  mismatches     = 0;
  lcdw_pkg::out_item_t awaited_writes[$];
  lcdw_pkg::out_item_t head_write;

  // Predicted controller state, starting from its reset values.
  logic [15:0] latched_cmd = '0;
  logic [15:0] col_lo      = '0;
  logic [15:0] col_hi      = '0;
  logic [15:0] page_lo     = '0;
  logic [15:0] page_hi     = '0;
  logic [15:0] cursor_col  = '0;
  logic [15:0] cursor_row  = '0;
  logic [2:0]  orient      = '0;
  logic [2:0]  words_seen  = '0;
  logic [15:0] held_words [3] = '{16'h0000, 16'h0000, 16'h0000};

  // Directed rows. After reset the orientation is zero, so x mirrors to 319 and
  // the one-column default window steps the row on every pixel.
  stim_row_t stim_rows [26] = '{
    '{ROW_SILENT,  '{1'b1, 1'b1, 16'hFFFF, 1'b0}, NO_OUT},
    '{ROW_FIXED,   '{1'b0, 1'b1, lcdw_pkg::CMD_RAMWR, 1'b0}, LEN_ERR},
    '{ROW_FIXED,   '{1'b0, 1'b0, 16'hFFFF, 1'b0},
                   '{lcdw_pkg::RES_PIXEL, 16'd319, 16'd0, 24'hFFFFFF}},
    '{ROW_FIXED,   '{1'b0, 1'b0, 16'h0000, 1'b1},
                   '{lcdw_pkg::RES_PIXEL, 16'd319, 16'd1, 24'h000000}},
    '{ROW_SILENT,  '{1'b0, 1'b1, lcdw_pkg::CMD_CASET, 1'b1}, NO_OUT},
    '{ROW_PREDICT, '{1'b0, 1'b0, 16'h0000, 1'b0}, NO_OUT},
    '{ROW_PREDICT, '{1'b0, 1'b0, 16'h000A, 1'b0}, NO_OUT},
    '{ROW_PREDICT, '{1'b0, 1'b0, 16'h0000, 1'b0}, NO_OUT},
    '{ROW_PREDICT, '{1'b0, 1'b0, 16'h0013, 1'b1}, NO_OUT},
    '{ROW_SILENT,  '{1'b0, 1'b1, lcdw_pkg::CMD_PASET, 1'b1}, NO_OUT},
    '{ROW_PREDICT, '{1'b0, 1'b0, 16'h00FF, 1'b0}, NO_OUT},
    '{ROW_PREDICT, '{1'b0, 1'b0, 16'hFFFF, 1'b0}, NO_OUT},
    '{ROW_PREDICT, '{1'b0, 1'b0, 16'h0001, 1'b0}, NO_OUT},
    '{ROW_PREDICT, '{1'b0, 1'b0, 16'h0002, 1'b1}, NO_OUT},
    '{ROW_SILENT,  '{1'b0, 1'b1, lcdw_pkg::CMD_MADCTL, 1'b1}, NO_OUT},
    '{ROW_PREDICT, '{1'b0, 1'b0, 16'h00E0, 1'b1}, NO_OUT},
    '{ROW_SILENT,  '{1'b0, 1'b1, lcdw_pkg::CMD_RAMWR, 1'b1}, NO_OUT},
    '{ROW_PREDICT, '{1'b0, 1'b0, 16'hF800, 1'b0}, NO_OUT},
    '{ROW_PREDICT, '{1'b0, 1'b0, 16'h001F, 1'b1}, NO_OUT},
    '{ROW_SILENT,  '{1'b0, 1'b1, lcdw_pkg::CMD_MADCTL, 1'b1}, NO_OUT},
    '{ROW_PREDICT, '{1'b0, 1'b0, 16'h0040, 1'b0}, NO_OUT},
    '{ROW_FIXED,   '{1'b0, 1'b0, 16'h0020, 1'b1}, LEN_ERR},
    '{ROW_SILENT,  '{1'b0, 1'b1, lcdw_pkg::CMD_CASET, 1'b1}, NO_OUT},
    '{ROW_FIXED,   '{1'b0, 1'b0, 16'h1234, 1'b1}, LEN_ERR},
    '{ROW_SILENT,  '{1'b0, 1'b1, 16'h0000, 1'b1}, NO_OUT},
    '{ROW_SILENT,  '{1'b0, 1'b0, 16'hABCD, 1'b1}, NO_OUT}
  };

  lcd_window_pixel_writer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Works out what one accepted word does to the controller and whether it
  // produces a pixel write or a length error.
  function automatic logic spi_word_effect(input lcdw_pkg::in_item_t w,
                                           output lcdw_pkg::out_item_t res);
    logic [15:0] px;
    logic [15:0] py;
    logic [15:0] tmp;
    logic [15:0] c;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [2:0]  need;
    logic [2:0]  idx;
    res = NO_OUT;
    if (w.reset_low) return 1'b0;
    if (w.is_command) begin
      latched_cmd = w.data_word;
      words_seen  = '0;
      if (!w.last_in_transfer) res = LEN_ERR;
      return !w.last_in_transfer;
    end
    if (latched_cmd == lcdw_pkg::CMD_RAMWR) begin
      c  = w.data_word;
      px = cursor_col;
      py = cursor_row;
      if (orient[0]) begin
        tmp = px;
        px  = py;
        py  = tmp;
      end
      if (orient[2]) py = 16'(PANEL_H - 1) - py;
      if (!orient[1]) px = 16'(PANEL_W - 1) - px;
      res = '{lcdw_pkg::RES_PIXEL, px, py,
              {c[15:11], c[15:13], c[10:5], c[10:9], c[4:0], c[4:2]}};
      if (cursor_col < col_hi) begin
        cursor_col = cursor_col + 16'd1;
      end else begin
        cursor_col = col_lo;
        cursor_row = cursor_row + 16'd1;
      end
      return 1'b1;
    end
    if (latched_cmd == lcdw_pkg::CMD_CASET || latched_cmd == lcdw_pkg::CMD_PASET)
      need = lcdw_pkg::WIN_LAST_IDX;
    else if (latched_cmd == lcdw_pkg::CMD_MADCTL) need = lcdw_pkg::MADCTL_LAST_IDX;
    else return 1'b0;
    idx = words_seen;
    if (w.last_in_transfer) begin
      words_seen = '0;
      if (idx != need) begin
        res = LEN_ERR;
        return 1'b1;
      end
      if (latched_cmd == lcdw_pkg::CMD_MADCTL) begin
        orient = w.data_word[7:5];
      end else begin
        lo = {held_words[0][7:0], 8'h00} + held_words[1];
        hi = {held_words[2][7:0], 8'h00} + w.data_word;
        if (latched_cmd == lcdw_pkg::CMD_CASET) begin
          col_lo = lo;
          col_hi = hi;
        end else begin
          page_lo = lo;
          page_hi = hi;
        end
        cursor_col = col_lo;
        cursor_row = page_lo;
      end
      return 1'b0;
    end
    if (idx < need) held_words[idx] = w.data_word;
    // The count sticks one past the last index once a transfer runs long.
    if (idx <= need) words_seen = idx + 3'd1;
    return 1'b0;
  endfunction

  function automatic lcdw_pkg::in_item_t spi_word(input logic rl, input logic cmd,
                                                  input logic [15:0] data,
                                                  input logic last);
    spi_word = '{rl, cmd, data, last};
  endfunction

  // Offers one item, idling first at the current rate, and records what it
  // should produce once the block takes it.
  task automatic send_word(input lcdw_pkg::in_item_t w, input row_check_t how = ROW_PREDICT,
                           input lcdw_pkg::out_item_t want = NO_OUT);
    logic                has_res;
    lcdw_pkg::out_item_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= w;
    do @(posedge clk); while (in_stall);
    has_res = spi_word_effect(w, res);
    case (how)
      ROW_FIXED: begin
        awaited_writes.push_back(want);
      end
      ROW_PREDICT: begin
        if (has_res) awaited_writes.push_back(res);
      end
      default: begin
      end
    endcase
  endtask

  // Mostly well-formed command sequences with random content, plus broken
  // transfers, unknown commands, reset-pin activity and raw noise.
  task automatic run_random(input int quota);
    int          done_cnt;
    int          pick;
    int          n;
    int          k;
    int          need_len;
    logic [15:0] cmd;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [15:0] pw [4];
    done_cnt = 0;
    while (done_cnt < quota) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        send_word(spi_word(1'b0, 1'b1, lcdw_pkg::CMD_RAMWR, $urandom_range(9) != 0));
        n = $urandom_range(1, 16);
        for (k = 0; k < n; k++) begin
          send_word(spi_word(1'b0, 1'b0, 16'($urandom_range(16'hFFFF)),
                             k == n - 1 || $urandom_range(3) == 0));
        end
        done_cnt += n + 1;
      end else if (pick < 58) begin
        cmd = $urandom_range(1) ? lcdw_pkg::CMD_CASET : lcdw_pkg::CMD_PASET;
        lo  = 16'($urandom_range(0, 480));
        hi  = lo + 16'($urandom_range(0, 9));
        pw[0] = {8'h00, lo[15:8]};
        pw[1] = {8'h00, lo[7:0]};
        pw[2] = {8'h00, hi[15:8]};
        pw[3] = {8'h00, hi[7:0]};
        // Now and then a full-width word, so the shift-and-add wraps.
        for (k = 0; k < 4; k++) begin
          if ($urandom_range(7) == 0) pw[k] = 16'($urandom_range(16'hFFFF));
        end
        send_word(spi_word(1'b0, 1'b1, cmd, 1'b1));
        for (k = 0; k < 4; k++) send_word(spi_word(1'b0, 1'b0, pw[k], k == 3));
        done_cnt += 5;
      end else if (pick < 68) begin
        send_word(spi_word(1'b0, 1'b1, lcdw_pkg::CMD_MADCTL, 1'b1));
        send_word(spi_word(1'b0, 1'b0, 16'($urandom_range(16'hFFFF)), 1'b1));
        done_cnt += 2;
      end else if (pick < 80) begin
        case ($urandom_range(2))
          0: cmd = lcdw_pkg::CMD_CASET;
          1: cmd = lcdw_pkg::CMD_PASET;
          default: cmd = lcdw_pkg::CMD_MADCTL;
        endcase
        need_len = (cmd == lcdw_pkg::CMD_MADCTL) ? 1 : 4;
        n = $urandom_range(1, 6);
        if (n == need_len) n++;
        send_word(spi_word(1'b0, 1'b1, cmd, 1'b1));
        for (k = 0; k < n; k++) begin
          send_word(spi_word(1'b0, 1'b0, 16'($urandom_range(16'hFFFF)), k == n - 1));
        end
        done_cnt += n + 1;
      end else if (pick < 85) begin
        cmd = 16'($urandom_range(16'hFFFF));
        if (cmd == lcdw_pkg::CMD_CASET || cmd == lcdw_pkg::CMD_PASET ||
            cmd == lcdw_pkg::CMD_RAMWR || cmd == lcdw_pkg::CMD_MADCTL)
          cmd = cmd ^ 16'h0100;
        send_word(spi_word(1'b0, 1'b1, cmd, 1'($urandom_range(1))));
        n = $urandom_range(0, 3);
        for (k = 0; k < n; k++) begin
          send_word(spi_word(1'b0, 1'b0, 16'($urandom_range(16'hFFFF)),
                             1'($urandom_range(1))));
        end
        done_cnt += n + 1;
      end else if (pick < 90) begin
        send_word(spi_word(1'b1, 1'($urandom_range(1)), 16'($urandom_range(16'hFFFF)),
                           1'($urandom_range(1))));
        done_cnt += 1;
      end else begin
        send_word(spi_word($urandom_range(7) == 0, 1'($urandom_range(1)),
                           16'($urandom_range(16'hFFFF)), 1'($urandom_range(1))));
        done_cnt += 1;
      end
    end
  endtask

  task automatic check_field(input string name, input logic [23:0] want,
                             input logic [23:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Each result the block hands over is matched against the oldest one owed.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_writes.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, out_item);
        mismatches++;
      end else begin
        head_write = awaited_writes.pop_front();
        check_field("result_kind", 24'(head_write.result_kind),
                    24'(out_item.result_kind));
        check_field("pixel_x", 24'(head_write.pixel_x), 24'(out_item.pixel_x));
        check_field("pixel_y", 24'(head_write.pixel_y), 24'(out_item.pixel_y));
        check_field("pixel_rgb", head_write.pixel_rgb, out_item.pixel_rgb);
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct  = 34;
    recv_stall_pct = 81;
    foreach (stim_rows[i]) begin
      send_word(stim_rows[i].stim, stim_rows[i].check, stim_rows[i].want);
    end
    run_random(205);

    send_idle_pct  = 81;
    recv_stall_pct = 34;
    run_random(205);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(205);

    in_valid <= 1'b0;
    while (awaited_writes.size() != 0) @(posedge clk);
    // A short tail after the last owed result catches strays.
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("lcd_window_pixel_writer verification clean");
    end else begin
      $display("lcd_window_pixel_writer verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("lcd_window_pixel_writer verification failed");
    $finish;
  end

endmodule
